[hdl/lgs_pkg.sv]
// shared types, constants and the row update function for the life grid block
`default_nettype none

package lgs_pkg;

  // grid size
  localparam int ROWS = 32;
  localparam int COLS = 32;

  // widths of the transaction fields
  localparam int FUNC_W = 2;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 5;

  // derived widths
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CNT_W = $clog2(ROWS + 3);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  // neighbor counts of the rule
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  // what the row window does in a cycle
  typedef enum logic [2:0] {
    WIN_NONE,
    WIN_UP,
    WIN_MID,
    WIN_STEP,
    WIN_LAST
  } win_op_t;

  // command from the controller to the datapath
  typedef struct packed {
    logic             load;      // latch the transaction fields
    logic             rd_en;     // read one row of the grid
    logic             rd_item;   // read address from the transaction row
    logic [ROW_W-1:0] rd_addr;   // read address during a sweep
    win_op_t          win_op;
    logic [ROW_W-1:0] wr_addr;   // row written by a sweep step
    logic             cell_wr;   // write one cell
    logic             res_en;    // register the result
    logic             res_read;  // the result is the cell read
  } dp_cmd_t;

  // new value of one row from its old upper, own and lower rows
  function automatic logic [COLS-1:0] next_row(input logic [COLS-1:0] up,
                                               input logic [COLS-1:0] mid,
                                               input logic [COLS-1:0] down);
    logic [COLS-1:0] res;
    logic [3:0]      n;
    int              l;
    int              r;
    res = '0;
    for (int c = 0; c < COLS; c++) begin
      l = (c == 0) ? COLS - 1 : c - 1;
      r = (c == COLS - 1) ? 0 : c + 1;
      n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(mid[l]) + 4'(mid[r])
        + 4'(down[l]) + 4'(down[c]) + 4'(down[r]);
      res[c] = mid[c] ? ((n == SURVIVE_LO) || (n == BIRTH_CNT)) : (n == BIRTH_CNT);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/life_grid_generation_step_top.sv]
// top level of the toroidal life grid: controller plus datapath
// write and read go through EXEC and FINISH to the done strobe; an advance
// runs the sweep that reads one grid row per cycle through the single memory
// read port and updates it a row later
// busy is high from the accepted start until the cycle the result is shown
// synchronous reset clears the grid to all dead through per-row valid bits
`default_nettype none

module life_grid_generation_step_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lgs_pkg::FUNC_W-1:0]      func,
  input  wire logic [lgs_pkg::ROW_FIELD_W-1:0] row,
  input  wire logic [lgs_pkg::COL_FIELD_W-1:0] col,
  input  wire logic                           value,
  output logic                                busy,
  output logic                                done,
  output logic                                cell_value
);
  import lgs_pkg::*;

  dp_cmd_t cmd;

  // sequencing of each transaction
  lgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // grid and row update
  lgs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .row        (row),
    .col        (col),
    .value      (value),
    .cell_value (cell_value)
  );

endmodule

`default_nettype wire

[hdl/lgs_datapath.sv]
// grid memory, row window and result register of the life grid block
`default_nettype none

module lgs_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lgs_pkg::dp_cmd_t               cmd,
  input  wire logic [lgs_pkg::ROW_FIELD_W-1:0] row,
  input  wire logic [lgs_pkg::COL_FIELD_W-1:0] col,
  input  wire logic                           value,
  output logic                                cell_value
);
  import lgs_pkg::*;

  // grid storage, one row per entry
  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;

  // transaction fields
  logic [ROW_FIELD_W-1:0] row_q;
  logic [COL_FIELD_W-1:0] col_q;
  logic                   value_q;

  // read data
  logic [COLS-1:0] rd_raw;
  logic            rd_valid;
  logic [COLS-1:0] rd_word;

  // row window of the sweep
  logic [COLS-1:0] up;
  logic [COLS-1:0] mid;
  logic [COLS-1:0] first;

  logic             on_grid;
  logic [ROW_W-1:0] row_idx;
  logic [COL_W-1:0] col_idx;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  logic [COLS-1:0]  wr_data;
  logic [COLS-1:0]  cell_row;

  // address decode, cell access uses the latched row
  always_comb begin
    on_grid = (32'(row_q) < ROWS) && (32'(col_q) < COLS);
    row_idx = ROW_W'(row_q);
    col_idx = COL_W'(col_q);
    rd_addr = cmd.rd_item ? row_idx : cmd.rd_addr;
    rd_word = rd_valid ? rd_raw : '0;
  end

  // row with the one cell replaced
  always_comb begin
    cell_row          = rd_word;
    cell_row[col_idx] = value_q;
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd.wr_addr;
    wr_data = next_row(up, mid, rd_word);
    case (cmd.win_op)
      WIN_STEP: begin
        wr_en = 1'b1;
      end
      WIN_LAST: begin
        wr_en   = 1'b1;
        wr_data = next_row(up, mid, first);
      end
      default: begin
        if (cmd.cell_wr && on_grid) begin
          wr_en   = 1'b1;
          wr_addr = row_idx;
          wr_data = cell_row;
        end
      end
    endcase
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // row valid bits, cleared at reset so the grid reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= row_valid[rd_addr] && !(wr_en && wr_addr == rd_addr && 1'b0);
      end
    end
  end

  // transaction fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q   <= row;
      col_q   <= col;
      value_q <= value;
    end
  end

  // row window
  always_ff @(posedge clk) begin
    case (cmd.win_op)
      WIN_UP: begin
        up <= rd_word;
      end
      WIN_MID: begin
        mid   <= rd_word;
        first <= rd_word;
      end
      WIN_STEP: begin
        up  <= mid;
        mid <= rd_word;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      cell_value <= cmd.res_read && on_grid && rd_word[col_idx];
    end
  end

endmodule

`default_nettype wire

[hdl/lgs_ctrl.sv]
// controller state machine of the life grid block
`default_nettype none

module lgs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lgs_pkg::FUNC_W-1:0] func,
  output logic                           busy,
  output logic                           done,
  output lgs_pkg::dp_cmd_t               cmd
);
  import lgs_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    FINISH,
    SWEEP
  } state_t;

  state_t             state;
  logic [FUNC_W-1:0]  func_q;
  logic [CNT_W-1:0]   cnt;

  assign busy = (state != IDLE);

  // commands for the datapath
  always_comb begin
    cmd          = '0;
    cmd.win_op   = WIN_NONE;
    cmd.rd_addr  = (cnt == '0) ? ROW_W'(ROWS - 1) : ROW_W'(cnt - CNT_W'(1));
    cmd.wr_addr  = (cnt == CNT_W'(ROWS + 2)) ? ROW_W'(ROWS - 1)
                                             : ROW_W'(cnt - CNT_W'(3));
    case (state)
      IDLE: begin
        cmd.load = start;
      end
      EXEC: begin
        if (func_q == FUNC_WRITE || func_q == FUNC_READ) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_item = 1'b1;
        end else if (func_q != FUNC_ADVANCE) begin
          cmd.res_en = 1'b1;
        end
      end
      FINISH: begin
        cmd.cell_wr  = (func_q == FUNC_WRITE);
        cmd.res_en   = 1'b1;
        cmd.res_read = (func_q == FUNC_READ);
      end
      SWEEP: begin
        cmd.rd_en = (cnt <= CNT_W'(ROWS));
        if (cnt == CNT_W'(1)) begin
          cmd.win_op = WIN_UP;
        end else if (cnt == CNT_W'(2)) begin
          cmd.win_op = WIN_MID;
        end else if (cnt == CNT_W'(ROWS + 2)) begin
          cmd.win_op = WIN_LAST;
          cmd.res_en = 1'b1;
        end else if (cnt >= CNT_W'(3)) begin
          cmd.win_op = WIN_STEP;
        end
      end
      default: begin
      end
    endcase
  end

  // state and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      done   <= 1'b0;
      cnt    <= '0;
      func_q <= FUNC_WRITE;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            func_q <= func;
            state  <= EXEC;
          end
        end
        EXEC: begin
          cnt <= '0;
          if (func_q == FUNC_WRITE || func_q == FUNC_READ) begin
            state <= FINISH;
          end else if (func_q == FUNC_ADVANCE) begin
            state <= SWEEP;
          end else begin
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        FINISH: begin
          done  <= 1'b1;
          state <= IDLE;
        end
        SWEEP: begin
          if (cnt == CNT_W'(ROWS + 2)) begin
            done  <= 1'b1;
            state <= IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
